/* hdl/ehp_pkg.sv */
// Package for the Ethernet/IPv4/L4 header parser.
// Holds frame offsets, protocol codes, status codes and the capture limit.
// No dependencies.
package ehp_pkg;

   // Captured byte count saturates here
   localparam logic [15:0] MAX_CAPTURE_BYTES = 16'd65535;

   // Frame byte offsets (IPv4 header without options)
   localparam logic [15:0] DEST_MAC_END   = 16'd6;
   localparam logic [15:0] SRC_MAC_END    = 16'd12;
   localparam logic [15:0] FRAG_HI_POS    = 16'd20;
   localparam logic [15:0] FRAG_LO_POS    = 16'd21;
   localparam logic [15:0] TTL_POS        = 16'd22;
   localparam logic [15:0] PROTO_POS      = 16'd23;
   localparam logic [15:0] SRC_ADDR_START = 16'd26;
   localparam logic [15:0] DST_ADDR_START = 16'd30;
   localparam logic [15:0] IP_HDR_END     = 16'd34;
   localparam logic [15:0] L4_WORDS_END   = 16'd38;
   localparam logic [15:0] SMALL_L4_END   = 16'd42;
   localparam logic [15:0] TCP_OFFSET_POS = 16'd46;
   localparam logic [15:0] TCP_FLAGS_POS  = 16'd47;

   // IPv4 protocol numbers
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_L4_SHORT  = 2'd1,
      STATUS_IP_SHORT  = 2'd2
   } status_type;

endpackage

/* hdl/eth_ipv4_l4_header_parser_top.sv */
// Top level of the Ethernet/IPv4/L4 header parser.
// Depends on ehp_pkg.
//
// Usage:
//   The req_ channel carries a captured frame one byte per transaction, in
//   wire order; req_last_byte marks the final captured byte. Header fields
//   are latched as their bytes pass. On the last byte one transaction goes
//   out on the rsp_ channel with the status, fragment flag, latched header
//   fields and payload length; every other byte gives no output.
//   Latency: the result is valid in the cycle after the last byte is taken.
//   Throughput: one byte per cycle, set by the single result register; a
//   new byte is taken while a result is being handed over, as long as the
//   result register is empty or drained in the same cycle.
//   When the receiver stalls with a result pending, req_ready drops until
//   rsp_ready returns, so no result is lost.
//   Reset clears the byte counter, all latched fields and the result valid.
//   The byte counter saturates at 65535; longer frames report that length.
module eth_ipv4_l4_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_fragmented,
   output logic [7:0]  rsp_ip_protocol,
   output logic [7:0]  rsp_time_to_live,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_destination_address,
   output logic [15:0] rsp_first_l4_word,
   output logic [15:0] rsp_second_l4_word,
   output logic [7:0]  rsp_tcp_flag_bits,
   output logic [15:0] rsp_payload_length,
   output logic [47:0] rsp_dest_mac,
   output logic [47:0] rsp_src_mac
);

   // Frame state
   logic [15:0] pos_ff, pos_in;
   logic [47:0] dmac_ff, dmac_in;
   logic [47:0] smac_ff, smac_in;
   logic [15:0] frag_ff, frag_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] saddr_ff, saddr_in;
   logic [31:0] daddr_ff, daddr_in;
   logic [31:0] l4w_ff, l4w_in;
   logic [3:0]  tcp_off_ff, tcp_off_in;
   logic        tcp_seen_ff, tcp_seen_in;
   logic [7:0]  flags_ff, flags_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   ehp_pkg::status_type  status_ff, status_in;
   logic                 frag_out_ff, frag_out_in;
   logic [15:0]          payload_ff, payload_in;
   logic [7:0]           rproto_ff, rttl_ff, rflags_ff;
   logic [31:0]          rsaddr_ff, rdaddr_ff, rl4w_ff;
   logic [47:0]          rdmac_ff, rsmac_ff;

   logic        accept;
   logic        done;
   logic [15:0] len;
   logic [15:0] tcp_hdr_len;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign done      = accept && req_last_byte;

   // Latch the current byte into its header field
   always_comb begin
      pos_in      = pos_ff;
      dmac_in     = dmac_ff;
      smac_in     = smac_ff;
      frag_in     = frag_ff;
      ttl_in      = ttl_ff;
      proto_in    = proto_ff;
      saddr_in    = saddr_ff;
      daddr_in    = daddr_ff;
      l4w_in      = l4w_ff;
      tcp_off_in  = tcp_off_ff;
      tcp_seen_in = tcp_seen_ff;
      flags_in    = flags_ff;
      if (accept) begin
         if (pos_ff < ehp_pkg::DEST_MAC_END) begin
            dmac_in = {dmac_ff[39:0], req_data_byte};
         end else if (pos_ff < ehp_pkg::SRC_MAC_END) begin
            smac_in = {smac_ff[39:0], req_data_byte};
         end else if (pos_ff == ehp_pkg::FRAG_HI_POS || pos_ff == ehp_pkg::FRAG_LO_POS) begin
            frag_in = {frag_ff[7:0], req_data_byte};
         end else if (pos_ff == ehp_pkg::TTL_POS) begin
            ttl_in = req_data_byte;
         end else if (pos_ff == ehp_pkg::PROTO_POS) begin
            proto_in = req_data_byte;
         end else if (pos_ff >= ehp_pkg::SRC_ADDR_START && pos_ff < ehp_pkg::DST_ADDR_START) begin
            saddr_in = {saddr_ff[23:0], req_data_byte};
         end else if (pos_ff >= ehp_pkg::DST_ADDR_START && pos_ff < ehp_pkg::IP_HDR_END) begin
            daddr_in = {daddr_ff[23:0], req_data_byte};
         end else if (pos_ff >= ehp_pkg::IP_HDR_END && pos_ff < ehp_pkg::L4_WORDS_END) begin
            l4w_in = {l4w_ff[23:0], req_data_byte};
         end else if (pos_ff == ehp_pkg::TCP_OFFSET_POS) begin
            tcp_off_in  = req_data_byte[7:4];
            tcp_seen_in = 1'b1;
         end else if (pos_ff == ehp_pkg::TCP_FLAGS_POS) begin
            flags_in = req_data_byte;
         end
         if (pos_ff < ehp_pkg::MAX_CAPTURE_BYTES) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   // Status and payload length from the updated frame state
   assign len         = pos_in;
   assign tcp_hdr_len = ehp_pkg::IP_HDR_END + {10'd0, tcp_off_in, 2'b00};
   assign frag_out_in = (frag_in[13:0] != 14'd0);

   always_comb begin
      status_in  = ehp_pkg::STATUS_OK;
      payload_in = 16'd0;
      if (len < ehp_pkg::IP_HDR_END) begin
         status_in = ehp_pkg::STATUS_IP_SHORT;
      end else if (frag_out_in) begin
         payload_in = len - ehp_pkg::IP_HDR_END;
      end else begin
         case (proto_in) inside
            ehp_pkg::PROTO_ICMP, ehp_pkg::PROTO_UDP: begin
               if (len < ehp_pkg::SMALL_L4_END) begin
                  status_in = ehp_pkg::STATUS_L4_SHORT;
               end else begin
                  payload_in = len - ehp_pkg::SMALL_L4_END;
               end
            end
            ehp_pkg::PROTO_TCP: begin
               if (!tcp_seen_in || tcp_hdr_len > len) begin
                  status_in = ehp_pkg::STATUS_L4_SHORT;
               end else begin
                  payload_in = len - tcp_hdr_len;
               end
            end
            default: begin
               payload_in = len - ehp_pkg::IP_HDR_END;
            end
         endcase
      end
   end

   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);

   // Frame state: clear after the last byte so the next byte starts a frame
   always_ff @(posedge clock) begin
      if (reset || done) begin
         pos_ff      <= '0;
         dmac_ff     <= '0;
         smac_ff     <= '0;
         frag_ff     <= '0;
         ttl_ff      <= '0;
         proto_ff    <= '0;
         saddr_ff    <= '0;
         daddr_ff    <= '0;
         l4w_ff      <= '0;
         tcp_off_ff  <= '0;
         tcp_seen_ff <= 1'b0;
         flags_ff    <= '0;
      end else begin
         pos_ff      <= pos_in;
         dmac_ff     <= dmac_in;
         smac_ff     <= smac_in;
         frag_ff     <= frag_in;
         ttl_ff      <= ttl_in;
         proto_ff    <= proto_in;
         saddr_ff    <= saddr_in;
         daddr_ff    <= daddr_in;
         l4w_ff      <= l4w_in;
         tcp_off_ff  <= tcp_off_in;
         tcp_seen_ff <= tcp_seen_in;
         flags_ff    <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result on the last byte; hold it otherwise
   always_ff @(posedge clock) begin
      if (done) begin
         status_ff   <= status_in;
         frag_out_ff <= frag_out_in;
         payload_ff  <= payload_in;
         rproto_ff   <= proto_in;
         rttl_ff     <= ttl_in;
         rsaddr_ff   <= saddr_in;
         rdaddr_ff   <= daddr_in;
         rl4w_ff     <= l4w_in;
         rflags_ff   <= flags_in;
         rdmac_ff    <= dmac_in;
         rsmac_ff    <= smac_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_fragmented          = frag_out_ff;
   assign rsp_ip_protocol         = rproto_ff;
   assign rsp_time_to_live        = rttl_ff;
   assign rsp_source_address      = rsaddr_ff;
   assign rsp_destination_address = rdaddr_ff;
   assign rsp_first_l4_word       = rl4w_ff[31:16];
   assign rsp_second_l4_word      = rl4w_ff[15:0];
   assign rsp_tcp_flag_bits       = rflags_ff;
   assign rsp_payload_length      = payload_ff;
   assign rsp_dest_mac            = rdmac_ff;
   assign rsp_src_mac             = rsmac_ff;

endmodule
